### src/apa_pkg.sv
// Shared types and codes for the address pool allocator.
// Used by apa_cell and address_pool_allocator_unit; depends on nothing.

package apa_pkg;

  // Field widths fixed by the interface.
  localparam int ADDR_W   = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  // Default pool depth for the top level.
  localparam int DEFAULT_POOL_SIZE = 256;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_ALLOC = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

  // Search token that walks the allocated-table chain, one cell per cycle.
  typedef struct packed {
    logic              active;     // a search is in this slot
    logic              is_alloc;   // 1: find an empty entry, 0: find a matching entry
    logic              may_clear;  // release may clear the matching entry
    logic              done;       // an entry was claimed or matched upstream
    logic [ADDR_W-1:0] addr;       // address to store or to look for
  } apa_token_t;

endpackage

### src/apa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used by address_pool_allocator_unit for the free ring.

module apa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/apa_cell.sv
// One entry of the allocated-address table, with its stage of the search chain.
// Depends on apa_pkg for the token type.

module apa_cell (
  input  logic               clk,
  input  logic               rst,
  input  apa_pkg::apa_token_t tok_in,
  output apa_pkg::apa_token_t tok_out
);

  logic                      valid;
  logic                      valid_next;
  logic [apa_pkg::ADDR_W-1:0] entry;
  logic [apa_pkg::ADDR_W-1:0] entry_next;
  apa_pkg::apa_token_t       tok_next;
  logic                      seek;
  logic                      hit_free;
  logic                      hit_match;

  // An open token either claims this entry when it is empty or matches it.
  always_comb begin
    seek       = tok_in.active && !tok_in.done;
    hit_free   = seek && tok_in.is_alloc && !valid;
    hit_match  = seek && !tok_in.is_alloc && valid && (entry == tok_in.addr);
    valid_next = valid;
    entry_next = entry;
    tok_next   = tok_in;
    if (hit_free) begin
      valid_next    = 1'b1;
      entry_next    = tok_in.addr;
      tok_next.done = 1'b1;
    end
    if (hit_match) begin
      tok_next.done = 1'b1;
      if (tok_in.may_clear) begin
        valid_next = 1'b0;
      end
    end
  end

  // Valid bit and token stage are control state and clear on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      tok_out <= '0;
    end else begin
      valid   <= valid_next;
      tok_out <= tok_next;
    end
  end

  // The stored address needs no reset; it is only read while valid is set.
  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

### src/address_pool_allocator_unit.sv
// Top level of the address pool allocator: free ring, control and search chain.
// Depends on apa_pkg, apa_ram and apa_cell.

// The block takes one command at a time and returns one result per command.
// A load or an unused command passes from S_IDLE through S_FIN to the result
// register. A release waits in S_SEARCH, and an allocate in S_READ and then
// S_SEARCH, before S_FIN, since the search token walks the row of POOL_SIZE
// table cells one cell per clock (an allocate first reads the head of the
// free ring from RAM). An allocate from an empty ring goes straight to S_FIN.
// in_stall stays high from the transfer of a command until its result has
// been placed in the output register; a waiting result does not block the
// next command. After reset the pool is empty and no clearing pass is needed.

module address_pool_allocator_unit #(
  parameter int POOL_SIZE = apa_pkg::DEFAULT_POOL_SIZE
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [apa_pkg::CMD_W-1:0]    cmd,
  input  logic [apa_pkg::ADDR_W-1:0]   addr_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [apa_pkg::STATUS_W-1:0] status,
  output logic [apa_pkg::ADDR_W-1:0]   addr_out
);

  localparam int IDX_W = $clog2(POOL_SIZE);
  localparam int CNT_W = $clog2(POOL_SIZE + 1);

  // Controller states.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_READ   = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;
  localparam logic [1:0] S_FIN    = 2'd3;

  logic [1:0]                    state;
  logic [IDX_W-1:0]              head;
  logic [CNT_W-1:0]              free_count;
  logic [apa_pkg::STATUS_W-1:0]  pend_status;
  logic [apa_pkg::ADDR_W-1:0]    pend_addr;

  logic                          accept;
  logic                          out_load;
  logic                          ring_full;
  logic [IDX_W:0]                tail_sum;
  logic [IDX_W:0]                tail_wrap;
  logic [IDX_W-1:0]              tail_idx;
  logic [IDX_W-1:0]              head_inc;
  logic [IDX_W-1:0]              head_dec;

  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic [apa_pkg::ADDR_W-1:0]    ram_wdata;
  logic [apa_pkg::ADDR_W-1:0]    ram_rdata;

  apa_pkg::apa_token_t           tok [POOL_SIZE+1];
  apa_pkg::apa_token_t           tail;

  // Handshake: one command in flight at a time.
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign ring_full = (free_count == CNT_W'(POOL_SIZE));
  assign out_load  = (state == S_FIN) && (!out_valid || !out_stall);

  // Ring index arithmetic, wrapping at POOL_SIZE.
  always_comb begin
    tail_sum  = (IDX_W+1)'(head) + (IDX_W+1)'(free_count);
    tail_wrap = (tail_sum >= (IDX_W+1)'(POOL_SIZE)) ?
                (tail_sum - (IDX_W+1)'(POOL_SIZE)) : tail_sum;
    tail_idx  = tail_wrap[IDX_W-1:0];
    head_inc  = (head == IDX_W'(POOL_SIZE - 1)) ? '0 : head + IDX_W'(1);
    head_dec  = (head == '0) ? IDX_W'(POOL_SIZE - 1) : head - IDX_W'(1);
  end

  // Free ring storage; the read port always looks at the head.
  apa_ram #(
    .WIDTH (apa_pkg::ADDR_W),
    .DEPTH (POOL_SIZE)
  ) u_free_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head),
    .rdata (ram_rdata)
  );

  // Loads append at the tail; a successful release pushes at the head.
  assign tail   = tok[POOL_SIZE];
  assign ram_we = (accept && (cmd == apa_pkg::CMD_LOAD) && !ring_full) ||
                  ((state == S_SEARCH) && tail.active && !tail.is_alloc &&
                   tail.done && tail.may_clear);
  assign ram_waddr = (state == S_IDLE) ? tail_idx : head_dec;
  assign ram_wdata = (state == S_IDLE) ? addr_in  : tail.addr;

  // Token injection at the front of the chain.
  always_comb begin
    tok[0] = '0;
    if (state == S_READ) begin
      tok[0].active   = 1'b1;
      tok[0].is_alloc = 1'b1;
      tok[0].addr     = ram_rdata;
    end else if (accept && (cmd == apa_pkg::CMD_RELEASE)) begin
      tok[0].active    = 1'b1;
      tok[0].may_clear = !ring_full;
      tok[0].addr      = addr_in;
    end
  end

  // Row of table cells; the token moves one cell per cycle.
  for (genvar i = 0; i < POOL_SIZE; i++) begin : g_cell
    apa_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  // Command sequencing, free ring bookkeeping and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      free_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      // The output register takes a finished result or empties after a transfer.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pend_addr <= '0;
            unique case (cmd)
              apa_pkg::CMD_LOAD: begin
                if (ring_full) begin
                  pend_status <= apa_pkg::STAT_FULL;
                end else begin
                  pend_status <= apa_pkg::STAT_OK;
                  free_count  <= free_count + CNT_W'(1);
                end
                state <= S_FIN;
              end
              apa_pkg::CMD_ALLOC: begin
                if (free_count == '0) begin
                  pend_status <= apa_pkg::STAT_EMPTY;
                  state       <= S_FIN;
                end else begin
                  state <= S_READ;
                end
              end
              apa_pkg::CMD_RELEASE: begin
                state <= S_SEARCH;
              end
              default: begin
                pend_status <= apa_pkg::STAT_OK;
                state       <= S_FIN;
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_SEARCH;
        end
        S_SEARCH: begin
          if (tail.active) begin
            if (tail.is_alloc) begin
              if (tail.done) begin
                head        <= head_inc;
                free_count  <= free_count - CNT_W'(1);
                pend_status <= apa_pkg::STAT_OK;
                pend_addr   <= tail.addr;
              end else begin
                pend_status <= apa_pkg::STAT_EMPTY;
              end
            end else if (tail.done && tail.may_clear) begin
              head        <= head_dec;
              free_count  <= free_count + CNT_W'(1);
              pend_status <= apa_pkg::STAT_OK;
            end else if (tail.done) begin
              pend_status <= apa_pkg::STAT_FULL;
            end else begin
              pend_status <= apa_pkg::STAT_NOT_ALLOC;
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_load) begin
            status   <= pend_status;
            addr_out <= pend_addr;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The free ring never holds more than the pool size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= CNT_W'(POOL_SIZE))
    else $error("free ring count exceeds pool size");

  // A search token only leaves the chain while the controller waits for it.
  a_tail_in_search: assert property (@(posedge clk) disable iff (rst)
    tail.active |-> (state == S_SEARCH))
    else $error("search token left the chain outside a search");

  // A failed or non-allocating result carries address zero.
  a_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != apa_pkg::STAT_OK)) |-> (addr_out == '0))
    else $error("nonzero address on an error result");

  // A command transfer always leaves the controller busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("controller idle right after a command transfer");

endmodule

### tb/address_pool_allocator_unit_test.sv
// Self-checking testbench for the address pool allocator top level.
// Depends on apa_pkg and address_pool_allocator_unit; it predicts every result on its own.
`timescale 1ns / 1ps

module address_pool_allocator_unit_test;

  localparam int POOL_SIZE   = apa_pkg::DEFAULT_POOL_SIZE;
  localparam int CYCLE_LIMIT = 3_000_000;
  // The command code that the block treats as a no-op.
  localparam logic [apa_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [apa_pkg::STATUS_W-1:0] status;
    logic [apa_pkg::ADDR_W-1:0]   addr;
  } pool_result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [apa_pkg::CMD_W-1:0]    cmd = apa_pkg::CMD_LOAD;
  logic [apa_pkg::ADDR_W-1:0]   addr_in = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [apa_pkg::STATUS_W-1:0] status;
  logic [apa_pkg::ADDR_W-1:0]   addr_out;

  // Predicted pool state: free ring and allocated table.
  logic [apa_pkg::ADDR_W-1:0] ring_addr [POOL_SIZE];
  int                         ring_head;
  int                         ring_count;
  logic [apa_pkg::ADDR_W-1:0] table_addr [POOL_SIZE];
  bit                         table_used [POOL_SIZE];

  pool_result_t expected_results[$];
  int           mismatches = 0;
  int           cycle_count = 0;
  bit           idling_on = 1'b1;
  int           hold_cycles = 0;
  int           stall_left = 0;

  address_pool_allocator_unit #(
    .POOL_SIZE(POOL_SIZE)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .addr_in   (addr_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .addr_out  (addr_out)
  );

  always #5 clk = ~clk;

  // Timeout guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** address_pool_allocator_unit: FAILED **");
      $finish;
    end
  end

  // Predict the result of one command and update the pool state.
  function automatic pool_result_t pool_predict(input logic [apa_pkg::CMD_W-1:0] op,
                                                input logic [apa_pkg::ADDR_W-1:0] a);
    pool_result_t r;
    int           slot;
    r.status = apa_pkg::STAT_OK;
    r.addr   = '0;
    slot     = -1;
    case (op)
      apa_pkg::CMD_LOAD: begin
        if (ring_count >= POOL_SIZE) begin
          r.status = apa_pkg::STAT_FULL;
        end else begin
          ring_addr[(ring_head + ring_count) % POOL_SIZE] = a;
          ring_count++;
        end
      end
      apa_pkg::CMD_ALLOC: begin
        for (int i = 0; i < POOL_SIZE; i++)
          if (slot < 0 && !table_used[i]) slot = i;
        if (ring_count == 0 || slot < 0) begin
          r.status = apa_pkg::STAT_EMPTY;
        end else begin
          r.addr = ring_addr[ring_head];
          ring_head = (ring_head + 1) % POOL_SIZE;
          ring_count--;
          table_addr[slot] = r.addr;
          table_used[slot] = 1'b1;
        end
      end
      apa_pkg::CMD_RELEASE: begin
        for (int i = 0; i < POOL_SIZE; i++)
          if (slot < 0 && table_used[i] && table_addr[i] == a) slot = i;
        if (slot < 0) begin
          r.status = apa_pkg::STAT_NOT_ALLOC;
        end else if (ring_count >= POOL_SIZE) begin
          r.status = apa_pkg::STAT_FULL;
        end else begin
          table_used[slot] = 1'b0;
          ring_head = (ring_head + POOL_SIZE - 1) % POOL_SIZE;
          ring_addr[ring_head] = a;
          ring_count++;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic int table_entries();
    int n;
    n = 0;
    foreach (table_used[i]) if (table_used[i]) n++;
    return n;
  endfunction

  // A random address that is currently allocated, or a random one if none is.
  function automatic logic [apa_pkg::ADDR_W-1:0] pick_allocated();
    int slots[$];
    foreach (table_used[i]) if (table_used[i]) slots.push_back(i);
    if (slots.size() == 0) return $urandom;
    return table_addr[slots[$urandom_range(0, slots.size() - 1)]];
  endfunction

  // Send one command and record its expected result once the transfer happens.
  task automatic send_cmd(input logic [apa_pkg::CMD_W-1:0] op,
                          input logic [apa_pkg::ADDR_W-1:0] a);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    cmd      <= op;
    addr_in  <= a;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(pool_predict(op, a));
  endtask

  // Stop offering commands and wait for every outstanding result.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Receiver side: long hold-off on request, otherwise short random stall bursts while idling_on is set.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (idling_on && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin : check_results
    pool_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d addr_out %h", status, addr_out);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status || addr_out !== want.addr) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d addr_out %h, got status %0d addr_out %h",
                     want.status, want.addr, status, addr_out);
        end
      end
    end
  end

  task automatic apply_reset();
    ring_head  = 0;
    ring_count = 0;
    foreach (table_used[i]) table_used[i] = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
  endtask

  // Extremes of the address, every command, duplicates and the empty and not-allocated error codes.
  task automatic test_directed();
    send_cmd(apa_pkg::CMD_ALLOC, 32'h0000_0000);
    send_cmd(apa_pkg::CMD_RELEASE, 32'h0000_0000);
    send_cmd(CMD_UNUSED, 32'hFFFF_FFFF);
    send_cmd(apa_pkg::CMD_LOAD, 32'h0000_0000);
    send_cmd(apa_pkg::CMD_LOAD, 32'hFFFF_FFFF);
    send_cmd(apa_pkg::CMD_LOAD, 32'hAAAA_5555);
    send_cmd(apa_pkg::CMD_LOAD, 32'h0000_0007);
    send_cmd(apa_pkg::CMD_LOAD, 32'h0000_0007);
    send_cmd(apa_pkg::CMD_ALLOC, 32'hFFFF_FFFF);
    send_cmd(apa_pkg::CMD_ALLOC, 32'h0000_0000);
    // A released address goes back to the head of the ring.
    send_cmd(apa_pkg::CMD_RELEASE, 32'hFFFF_FFFF);
    send_cmd(apa_pkg::CMD_ALLOC, 32'h5555_AAAA);
    send_cmd(apa_pkg::CMD_ALLOC, 32'h0000_0000);
    send_cmd(apa_pkg::CMD_ALLOC, 32'h0000_0000);
    send_cmd(apa_pkg::CMD_ALLOC, 32'h0000_0000);
    // Two copies of one address are both allocated; a third release misses.
    send_cmd(apa_pkg::CMD_RELEASE, 32'h0000_0007);
    send_cmd(apa_pkg::CMD_RELEASE, 32'h0000_0007);
    send_cmd(apa_pkg::CMD_RELEASE, 32'h0000_0007);
    send_cmd(apa_pkg::CMD_RELEASE, 32'hAAAA_5554);
    send_cmd(apa_pkg::CMD_RELEASE, 32'h0000_0000);
    send_cmd(apa_pkg::CMD_ALLOC, 32'h0000_0000);
    send_cmd(CMD_UNUSED, 32'h0000_0000);
    send_cmd(apa_pkg::CMD_LOAD, 32'h5555_AAAA);
    wait_drained();
  endtask

  // The receiver holds off while fast commands pile up behind the output.
  task automatic test_backpressure();
    hold_cycles = 300;
    for (int i = 0; i < 12; i++)
      send_cmd((i % 4 == 3) ? CMD_UNUSED : apa_pkg::CMD_LOAD, $urandom);
    wait_drained();
  endtask

  // Full ring on load and on release, and an allocate against a full table.
  task automatic test_pool_limits();
    while (ring_count < POOL_SIZE) send_cmd(apa_pkg::CMD_LOAD, $urandom);
    repeat (2) send_cmd(apa_pkg::CMD_LOAD, $urandom);
    send_cmd(apa_pkg::CMD_ALLOC, $urandom);
    send_cmd(apa_pkg::CMD_LOAD, $urandom);
    send_cmd(apa_pkg::CMD_RELEASE, pick_allocated());
    while (table_entries() < POOL_SIZE) begin
      if (ring_count == 0) send_cmd(apa_pkg::CMD_LOAD, $urandom);
      else send_cmd(apa_pkg::CMD_ALLOC, $urandom);
    end
    if (ring_count == 0) send_cmd(apa_pkg::CMD_LOAD, $urandom);
    send_cmd(apa_pkg::CMD_ALLOC, $urandom);
    // Release until the ring is full again; more addresses circulate than fit.
    while (ring_count < POOL_SIZE) send_cmd(apa_pkg::CMD_RELEASE, pick_allocated());
    send_cmd(apa_pkg::CMD_RELEASE, pick_allocated());
    wait_drained();
  endtask

  // Random mix of loads, allocates, releases and unused codes; releases mostly hit live addresses, a few miss.
  task automatic test_random(input int count);
    int                         pick;
    int                         load_pct;
    logic [apa_pkg::ADDR_W-1:0] a;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      load_pct = (ring_count > 192) ? 15 : (ring_count < 32) ? 50 : 30;
      case ($urandom_range(0, 4))
        0:       a = $urandom_range(0, 15);
        1:       a = 32'hFFFF_FFFF - $urandom_range(0, 3);
        default: a = $urandom;
      endcase
      if (pick < 4) begin
        send_cmd(CMD_UNUSED, a);
      end else if (pick < 4 + load_pct) begin
        send_cmd(apa_pkg::CMD_LOAD, a);
      end else if (pick < 70) begin
        send_cmd(apa_pkg::CMD_ALLOC, a);
      end else if ($urandom_range(0, 3) != 0) begin
        send_cmd(apa_pkg::CMD_RELEASE, pick_allocated());
      end else begin
        send_cmd(apa_pkg::CMD_RELEASE, a);
      end
    end
    wait_drained();
  endtask

  initial begin
    apply_reset();
    test_directed();
    test_backpressure();
    test_pool_limits();
    test_random(500);
    idling_on = 1'b0;
    test_random(100);
    repeat (POOL_SIZE + 16) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("** address_pool_allocator_unit: PASSED **");
    end else begin
      $display("** address_pool_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule
